@@ sv/mpa_pkg.sv @@
// Shared types and constants for the 2-D max pooling block with argmax.
// No dependencies; every other file refers to it by scoped names.
package mpa_pkg;

   // field and register widths
   localparam int SAMPLE_W  = 16;
   localparam int INDEX_W   = 12;
   localparam int POOL_W    = 4;
   localparam int DIM_W     = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 7;

   // internal widths: cursor, cursor times stride, signed window coordinate,
   // plane side plus padding, signed row base product
   localparam int CUR_W   = 8;
   localparam int PROD_W  = 12;
   localparam int COORD_W = 10;
   localparam int SPAN_W  = 8;
   localparam int RBP_W   = 18;

   // register reset values
   localparam logic [POOL_W-1:0] POOL_SIZE_RST = 4'd2;
   localparam logic [POOL_W-1:0] STRIDE_RST    = 4'd2;
   localparam logic [POOL_W-1:0] PADDING_RST   = 4'd0;
   localparam logic [DIM_W-1:0]  IN_WIDTH_RST  = 7'd64;
   localparam logic [DIM_W-1:0]  IN_HEIGHT_RST = 7'd64;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_FETCH = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POOL_SIZE = 3'd0,
      CSR_STRIDE    = 3'd1,
      CSR_PADDING   = 3'd2,
      CSR_IN_WIDTH  = 3'd3,
      CSR_IN_HEIGHT = 3'd4
   } csr_index_type;

endpackage

@@ sv/mpa_if.sv @@
// Valid/ready channel interfaces for the pooling block's request and response.
// Depends on mpa_pkg for the payload widths.
interface mpa_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  opcode;
   logic signed [mpa_pkg::SAMPLE_W-1:0]   sample_value;

   modport source (output valid, output opcode, output sample_value, input ready);
   modport sink   (input valid, input opcode, input sample_value, output ready);
endinterface

interface mpa_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [mpa_pkg::SAMPLE_W-1:0]   max_value;
   logic        [mpa_pkg::INDEX_W-1:0]    max_index;
   logic                                  no_valid;
   logic                                  last;

   modport source (output valid, output max_value, output max_index, output no_valid,
                   output last, input ready);
   modport sink   (input valid, input max_value, input max_index, input no_valid,
                   input last, output ready);
endinterface

@@ sv/mpa_store.sv @@
// Plane sample store: one write port and one read port, read data registered.
// Depends on mpa_pkg for the sample width.
module mpa_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [AW-1:0]                        wr_addr,
   input  logic signed [mpa_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic                                 rd_en,
   input  logic [AW-1:0]                        rd_addr,
   output logic signed [mpa_pkg::SAMPLE_W-1:0]  rd_data
);

   logic signed [mpa_pkg::SAMPLE_W-1:0] plane_ram [DEPTH];
   logic signed [mpa_pkg::SAMPLE_W-1:0] rd_data_ff;

   // write one sample per transfer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         plane_ram[wr_addr] <= wr_data;
      end
   end

   // registered read: the data follows rd_en in the next cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= plane_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/max_pool_2d_argmax.sv @@
// 2-D max pooling with argmax over one plane of signed 16-bit samples.
// Depends on mpa_pkg, mpa_req_if / mpa_rsp_if and mpa_store.
//
// Usage: the request channel carries an opcode and a sample. A load (opcode 0)
// writes the sample at the write pointer in raster order; loads stream one per
// cycle while no fetch is in progress. After in_width*in_height loads the
// write pointer and the output cursor return to zero. A fetch (opcode 1) pools
// the window of the next output position and returns max_value, max_index,
// no_valid and last on the response channel. If the padded plane is smaller
// than the window, a fetch gives no response and the cursor holds.
// A fetch steps through the setup, origin, base, scan, drain and done states;
// done loads the response register and returns to idle, so the response and
// the ready for the next request show together. The scan visits one window
// position per cycle, reading in-plane ones through the single store read port.
// The response sits in an output register: loads are still taken while it
// waits; a finished fetch holds in its last step until the register frees.
// Reset (synchronous, active high) restores the register defaults and clears the
// write pointer, cursor and response valid, not the store. The user writes the
// registers through the csr_ port only while the block is idle: not enforced.
module max_pool_2d_argmax #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int MAX_POOL   = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   mpa_req_if.sink                           req_chan,
   mpa_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [mpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mpa_pkg::CSR_W-1:0]         csr_wr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (AW + 1 > 14) ? AW + 1 : 14;
   localparam logic [mpa_pkg::DIM_W-1:0]  MAX_W = 7'((MAX_WIDTH > 127) ? 127 : MAX_WIDTH);
   localparam logic [mpa_pkg::DIM_W-1:0]  MAX_H = 7'((MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT);
   localparam logic [mpa_pkg::POOL_W-1:0] MAX_P = 4'((MAX_POOL > 15) ? 15 : MAX_POOL);

   localparam int PW  = mpa_pkg::PROD_W;
   localparam int KW  = mpa_pkg::COORD_W;
   localparam int SW  = mpa_pkg::SPAN_W;
   localparam int DW  = mpa_pkg::DIM_W;
   localparam int QW  = mpa_pkg::POOL_W;
   localparam int UW  = mpa_pkg::CUR_W;
   localparam int VW  = mpa_pkg::SAMPLE_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ORIGIN,
      ST_BASE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [QW-1:0] pool_size_ff, pool_size_in;
   logic [QW-1:0] stride_ff, stride_in;
   logic [QW-1:0] padding_ff, padding_in;
   logic [DW-1:0] in_width_ff, in_width_in;
   logic [DW-1:0] in_height_ff, in_height_in;

   logic [AW-1:0] wp_ff, wp_in;
   logic [UW-1:0] col_ff, col_in;
   logic [UW-1:0] row_ff, row_in;
   logic [PW-1:0] colp_ff, colp_in;
   logic [PW-1:0] rowp_ff, rowp_in;
   logic          last_col_ff, last_col_in;
   logic          last_row_ff, last_row_in;

   logic signed [KW-1:0] y_ff, y_in;
   logic signed [KW-1:0] x_ff, x_in;
   logic signed [KW-1:0] x0_ff, x0_in;
   logic [AW-1:0]        rbase_ff, rbase_in;
   logic [QW-1:0]        n_ff, n_in;
   logic [QW-1:0]        m_ff, m_in;

   logic                 rd_pend_ff, rd_pend_in;
   logic [AW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 found_ff, found_in;
   logic signed [VW-1:0] best_ff, best_in;
   logic [AW-1:0]        best_idx_ff, best_idx_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0]                 rsp_value_ff, rsp_value_in;
   logic [mpa_pkg::INDEX_W-1:0]          rsp_index_ff, rsp_index_in;
   logic                                 rsp_none_ff, rsp_none_in;
   logic                                 rsp_last_ff, rsp_last_in;

   // effective configuration
   logic [QW-1:0]  size_e, step_e;
   logic [DW-1:0]  w_e, h_e;
   logic [SW-1:0]  span_x, span_y, lim_x, lim_y;
   logic           too_big;
   logic [CW-1:0]  total;

   // datapath helpers
   logic [AW-1:0]        wp_eff;
   logic [CW-1:0]        wp_next;
   logic                 wp_wrap;
   logic                 in_range;
   logic [PW-1:0]        colp_e, rowp_e;
   logic [2:0]           shift;
   logic signed [mpa_pkg::RBP_W-1:0] rb_prod;
   logic                 pos_ok;
   logic [AW-1:0]        idx;

   // store ports
   logic                 wr_en;
   logic                 rd_en;
   logic signed [VW-1:0] rd_data;

   mpa_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_eff),
      .wr_data (req_chan.sample_value),
      .rd_en   (rd_en),
      .rd_addr (idx),
      .rd_data (rd_data)
   );

   // clamp the registers into their working ranges
   always_comb begin
      if (pool_size_ff == '0) begin
         size_e = 4'd1;
      end else if (pool_size_ff > MAX_P) begin
         size_e = MAX_P;
      end else begin
         size_e = pool_size_ff;
      end
      step_e = (stride_ff == '0) ? 4'd1 : stride_ff;
      if (in_width_ff == '0) begin
         w_e = 7'd1;
      end else if (in_width_ff > MAX_W) begin
         w_e = MAX_W;
      end else begin
         w_e = in_width_ff;
      end
      if (in_height_ff == '0) begin
         h_e = 7'd1;
      end else if (in_height_ff > MAX_H) begin
         h_e = MAX_H;
      end else begin
         h_e = in_height_ff;
      end
      span_x  = SW'(w_e) + SW'(padding_ff);
      span_y  = SW'(h_e) + SW'(padding_ff);
      too_big = (span_x < SW'(size_e)) || (span_y < SW'(size_e));
      lim_x   = span_x - SW'(size_e);
      lim_y   = span_y - SW'(size_e);
      total   = CW'(w_e) * CW'(h_e);
   end

   // load addressing and window addressing
   always_comb begin
      wp_eff   = (CW'(wp_ff) >= total) ? '0 : wp_ff;
      wp_next  = CW'(wp_eff) + CW'(1);
      wp_wrap  = (wp_next >= total);
      in_range = (colp_ff <= PW'(lim_x)) && (rowp_ff <= PW'(lim_y));
      colp_e   = in_range ? colp_ff : '0;
      rowp_e   = in_range ? rowp_ff : '0;
      shift    = padding_ff[3:1];
      rb_prod  = y_ff * $signed({1'b0, w_e});
      pos_ok   = !y_ff[KW-1] && (y_ff < $signed(KW'(h_e)))
              && !x_ff[KW-1] && (x_ff < $signed(KW'(w_e)));
      idx      = rbase_ff + AW'(x_ff);
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.max_value = rsp_value_ff;
   assign rsp_chan.max_index = rsp_index_ff;
   assign rsp_chan.no_valid  = rsp_none_ff;
   assign rsp_chan.last      = rsp_last_ff;

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      pool_size_in = pool_size_ff;
      stride_in    = stride_ff;
      padding_in   = padding_ff;
      in_width_in  = in_width_ff;
      in_height_in = in_height_ff;
      wp_in        = wp_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      colp_in      = colp_ff;
      rowp_in      = rowp_ff;
      last_col_in  = last_col_ff;
      last_row_in  = last_row_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      x0_in        = x0_ff;
      rbase_in     = rbase_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      rsp_none_in  = rsp_none_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      // register writes
      if (csr_wr_en) begin
         unique case (csr_index)
            mpa_pkg::CSR_POOL_SIZE: pool_size_in = csr_wr_data[QW-1:0];
            mpa_pkg::CSR_STRIDE:    stride_in    = csr_wr_data[QW-1:0];
            mpa_pkg::CSR_PADDING:   padding_in   = csr_wr_data[QW-1:0];
            mpa_pkg::CSR_IN_WIDTH:  in_width_in  = csr_wr_data[DW-1:0];
            mpa_pkg::CSR_IN_HEIGHT: in_height_in = csr_wr_data[DW-1:0];
            default: ;
         endcase
      end

      // drop the response once the receiver takes it
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // compare the sample read in the previous cycle
      if (rd_pend_ff && (!found_ff || (rd_data > best_ff))) begin
         found_in    = 1'b1;
         best_in     = rd_data;
         best_idx_in = rd_idx_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.opcode == mpa_pkg::OP_LOAD) begin
                  wr_en = 1'b1;
                  if (wp_wrap) begin
                     wp_in  = '0;
                     col_in = '0;
                     row_in = '0;
                  end else begin
                     wp_in = wp_next[AW-1:0];
                  end
               end else if (!too_big) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            colp_in  = PW'(col_ff) * PW'(step_e);
            rowp_in  = PW'(row_ff) * PW'(step_e);
            state_in = ST_ORIGIN;
         end
         ST_ORIGIN: begin
            // restart the cursor when it lies outside the output plane
            if (!in_range) begin
               col_in = '0;
               row_in = '0;
            end
            last_col_in = (colp_e + PW'(step_e)) > PW'(lim_x);
            last_row_in = (rowp_e + PW'(step_e)) > PW'(lim_y);
            y_in        = KW'(rowp_e) - KW'(shift);
            x_in        = KW'(colp_e) - KW'(shift);
            x0_in       = KW'(colp_e) - KW'(shift);
            n_in        = '0;
            m_in        = '0;
            found_in    = 1'b0;
            best_in     = mpa_pkg::SAMPLE_MIN;
            best_idx_in = '0;
            state_in    = ST_BASE;
         end
         ST_BASE: begin
            rbase_in = AW'(rb_prod);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // issue one read per in-plane window position
            rd_en      = pos_ok;
            rd_pend_in = pos_ok;
            rd_idx_in  = idx;
            if (m_ff == size_e - 4'd1) begin
               m_in     = '0;
               x_in     = x0_ff;
               n_in     = n_ff + 4'd1;
               y_in     = y_ff + KW'(1);
               rbase_in = rbase_ff + AW'(w_e);
               if (n_ff == size_e - 4'd1) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               m_in = m_ff + 4'd1;
               x_in = x_ff + KW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hand over the result and advance the cursor
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = best_ff;
               rsp_index_in = mpa_pkg::INDEX_W'(best_idx_ff);
               rsp_none_in  = !found_ff;
               rsp_last_in  = last_col_ff && last_row_ff;
               if (last_col_ff) begin
                  col_in = '0;
                  row_in = last_row_ff ? '0 : row_ff + UW'(1);
               end else begin
                  col_in = col_ff + UW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pool_size_ff <= mpa_pkg::POOL_SIZE_RST;
         stride_ff    <= mpa_pkg::STRIDE_RST;
         padding_ff   <= mpa_pkg::PADDING_RST;
         in_width_ff  <= mpa_pkg::IN_WIDTH_RST;
         in_height_ff <= mpa_pkg::IN_HEIGHT_RST;
         wp_ff        <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_size_ff <= pool_size_in;
         stride_ff    <= stride_in;
         padding_ff   <= padding_in;
         in_width_ff  <= in_width_in;
         in_height_ff <= in_height_in;
         wp_ff        <= wp_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      colp_ff      <= colp_in;
      rowp_ff      <= rowp_in;
      last_col_ff  <= last_col_in;
      last_row_ff  <= last_row_in;
      y_ff         <= y_in;
      x_ff         <= x_in;
      x0_ff        <= x0_in;
      rbase_ff     <= rbase_in;
      n_ff         <= n_in;
      m_ff         <= m_in;
      rd_idx_ff    <= rd_idx_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_none_ff  <= rsp_none_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // store writes happen only between fetches
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_IDLE))
      else $error("store written while a fetch is in progress");

   // a pending compare always follows a scan cycle
   a_read_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> ($past(state_ff) == ST_SCAN))
      else $error("read data compared outside the window scan");

   // a new response comes only from the final fetch step
   a_rsp_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside the final fetch step");

   // the last load of a plane rewinds pointer and cursor
   a_plane_wrap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && wp_wrap && !csr_wr_en) |=> (wp_ff == '0 && col_ff == '0 && row_ff == '0))
      else $error("pointer or cursor not rewound after the final load");

endmodule
